// File: design/dahsd_pkg.sv
`timescale 1ns / 1ps

package dahsd_pkg;

	localparam int AMOUNT_BITS = 17;
	localparam int PERIOD_BITS = 8;
	localparam int PHASE_BITS  = 3;
	localparam int COIL_BITS   = 4;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_H_NEG   = 3'd0;
	localparam mode_t MODE_H_POS   = 3'd1;
	localparam mode_t MODE_V_NEG   = 3'd2;
	localparam mode_t MODE_V_POS   = 3'd3;
	localparam mode_t MODE_STOPPED = 3'd4;

	localparam logic ACT_MOVE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic REG_H_PERIOD = 1'b0;
	localparam logic REG_V_PERIOD = 1'b1;

	localparam logic [PERIOD_BITS-1:0] H_PERIOD_RESET = 8'd15;
	localparam logic [PERIOD_BITS-1:0] V_PERIOD_RESET = 8'd22;
	localparam logic [PERIOD_BITS-1:0] PERIOD_IN_USE_RESET = 8'd10;

	typedef logic [AMOUNT_BITS-1:0] mag_t;
	typedef logic [PERIOD_BITS-1:0] period_t;
	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic [COIL_BITS-1:0] coils_t;

	// Half-step pattern: single coil and coil pairs in turn.
	function automatic coils_t coil_pattern(input phase_t ph);
		coils_t pat;
		unique case (ph)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			default: pat = 4'h9;
		endcase
		return pat;
	endfunction

endpackage

// File: design/dahsd_cmd_if.sv
`timescale 1ns / 1ps

interface dahsd_cmd_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       action;
	logic                                       axis;
	logic signed [dahsd_pkg::AMOUNT_BITS-1:0]   amount;

	modport source (output valid, action, axis, amount, input ready);
	modport sink (input valid, action, axis, amount, output ready);
endinterface

// File: design/dahsd_res_if.sv
`timescale 1ns / 1ps

interface dahsd_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [dahsd_pkg::COIL_BITS-1:0]      coils;
	logic                                 h_enable;
	logic                                 v_enable;
	logic                                 running;

	modport source (output valid, coils, h_enable, v_enable, running, input ready);
	modport sink (input valid, coils, h_enable, v_enable, running, output ready);
endinterface

// File: design/dual_axis_half_step_driver_top.sv
// Two stepper axes sharing four coil lines, one axis enabled at a time.
// Channel cmd carries words of action, axis and amount: a move command
// (action 0) or a one millisecond tick (action 1). Channel res returns one
// word per accepted cmd word: coil lines, both enables and a running flag,
// showing the state after that word.
// A tick goes to S_PUT and then to the output register; cmd is ready again
// in the cycle in which its answer appears. A move command runs a bit-serial
// divide of the duration by the axis period, one quotient bit per cycle,
// and its answer then passes through S_PUT to the output register. cmd is
// low on ready while a word is in work. The period registers are written
// through cfg_we, cfg_index and cfg_data, index 0 horizontal and index 1
// vertical; the user must write them only while the block is idle, which
// the block itself does not enforce. Reset stops both axes, drops coils and
// enables and loads periods 15 and 22. If res is stalled, the answer waits
// in its output register; one more word is accepted and then waits in S_PUT.
`timescale 1ns / 1ps

module dual_axis_half_step_driver_top #(
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dahsd_cmd_if.sink                         cmd,
	dahsd_res_if.source                       res,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [dahsd_pkg::PERIOD_BITS-1:0] cfg_data
);
	import dahsd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_PUT  = 3'b100
	} state_t;

	state_t                 state_q;
	period_t                h_period_q;
	period_t                v_period_q;
	mode_t                  mode_q;
	phase_t                 phase_q;
	logic [COUNT_BITS-1:0]  steps_q;
	period_t                period_q;
	period_t                cd_q;
	coils_t                 coils_q;
	logic [1:0]             enables_q;

	logic                   axis_q;
	logic                   neg_q;
	logic                   zero_q;
	period_t                per_q;

	logic                   res_valid_q;
	coils_t                 res_coils_q;
	logic                   res_h_q;
	logic                   res_v_q;
	logic                   res_run_q;

	logic                   accept;
	logic                   div_start;
	logic                   div_done;
	mag_t                   div_quo;
	mag_t                   mag;
	period_t                per_sel;
	logic [COUNT_BITS-1:0]  cnt;
	logic [COUNT_BITS-1:0]  steps_dec;
	phase_t                 phase_nxt;
	mode_t                  new_mode;
	logic                   out_free;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign div_start = accept && (cmd.action == ACT_MOVE);
	assign out_free  = !res_valid_q || res.ready;

	// Two's complement magnitude; the most negative pattern gives 65536.
	assign mag     = cmd.amount[AMOUNT_BITS-1] ? (mag_t'(0) - mag_t'(cmd.amount))
	                                           : mag_t'(cmd.amount);
	assign per_sel = cmd.axis ? v_period_q : h_period_q;

	dahsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  ((per_sel == '0) ? PERIOD_BITS'(1) : per_sel),
		.done     (div_done),
		.quotient (div_quo)
	);

	generate
		if (COUNT_BITS < AMOUNT_BITS) begin : g_sat
			assign cnt = (|div_quo[AMOUNT_BITS-1:COUNT_BITS]) ? '1
			                                                  : div_quo[COUNT_BITS-1:0];
		end else begin : g_nosat
			assign cnt = COUNT_BITS'(div_quo);
		end
	endgenerate

	assign steps_dec = steps_q - COUNT_BITS'(1);
	assign phase_nxt = mode_q[0] ? (phase_q - PHASE_BITS'(1)) : (phase_q + PHASE_BITS'(1));
	assign new_mode  = zero_q ? MODE_STOPPED : {1'b0, axis_q, !neg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_period_q <= H_PERIOD_RESET;
			v_period_q <= V_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_H_PERIOD: h_period_q <= cfg_data;
				REG_V_PERIOD: v_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= MODE_STOPPED;
			phase_q   <= '0;
			steps_q   <= '0;
			period_q  <= PERIOD_IN_USE_RESET;
			cd_q      <= '0;
			coils_q   <= '0;
			enables_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd.action == ACT_TICK) begin
						state_q <= S_PUT;
						if (steps_q != '0) begin
							if (cd_q == '0) begin
								steps_q <= steps_dec;
								cd_q    <= period_q - PERIOD_BITS'(1);
								if (steps_dec == '0 || mode_q == MODE_STOPPED) begin
									mode_q    <= MODE_STOPPED;
									coils_q   <= '0;
									enables_q <= '0;
								end else begin
									phase_q <= phase_nxt;
									coils_q <= coil_pattern(phase_nxt);
								end
							end else begin
								cd_q <= cd_q - PERIOD_BITS'(1);
							end
						end
					end else if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q  <= S_PUT;
						period_q <= per_q;
						if (new_mode != mode_q) begin
							mode_q    <= new_mode;
							enables_q <= (new_mode == MODE_STOPPED) ? 2'b00
							           : (axis_q ? 2'b10 : 2'b01);
						end
						steps_q <= cnt;
						if (steps_q == '0 && cnt != '0) begin
							cd_q <= '0;
						end
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command fields held for the end of the divide.
	always_ff @(posedge clk) begin
		if (div_start) begin
			axis_q <= cmd.axis;
			neg_q  <= cmd.amount[AMOUNT_BITS-1];
			zero_q <= (cmd.amount == '0);
			per_q  <= (per_sel == '0) ? PERIOD_BITS'(1) : per_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_PUT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && out_free) begin
			res_coils_q <= coils_q;
			res_h_q     <= enables_q[0];
			res_v_q     <= enables_q[1];
			res_run_q   <= (steps_q != '0);
		end
	end

	assign res.valid    = res_valid_q;
	assign res.coils    = res_coils_q;
	assign res.h_enable = res_h_q;
	assign res.v_enable = res_v_q;
	assign res.running  = res_run_q;

endmodule

// File: design/dahsd_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module dahsd_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [dahsd_pkg::AMOUNT_BITS-1:0] dividend,
	input  logic [dahsd_pkg::PERIOD_BITS-1:0] divisor,
	output logic                              done,
	output logic [dahsd_pkg::AMOUNT_BITS-1:0] quotient
);
	import dahsd_pkg::*;

	localparam int CNT_BITS = $clog2(AMOUNT_BITS + 1);

	logic [CNT_BITS-1:0]    cnt_q;
	logic                   done_q;
	period_t                rem_q;
	period_t                div_q;
	mag_t                   quo_q;
	logic [PERIOD_BITS:0]   trial;
	logic                   fits;

	assign trial = {rem_q, quo_q[AMOUNT_BITS-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_BITS'(AMOUNT_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			// The remainder stays below the divisor, so it fits the period width.
			rem_q <= fits ? PERIOD_BITS'(trial - {1'b0, div_q}) : PERIOD_BITS'(trial);
			quo_q <= {quo_q[AMOUNT_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: bench/dual_axis_half_step_driver_top_tb.sv
`timescale 1ns / 1ps

module dual_axis_half_step_driver_top_tb;
	import dahsd_pkg::*;

	localparam int COUNT_BITS   = 16;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_WORDS = 330;

	localparam coils_t HALF_STEP [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

	typedef struct packed {
		coils_t coils;
		logic   h_enable;
		logic   v_enable;
		logic   running;
	} drive_state_t;

	class drive_scoreboard;
		period_t               h_period;
		period_t               v_period;
		period_t               period_in_use;
		period_t               ms_left;
		mode_t                 mode;
		phase_t                phase;
		logic [COUNT_BITS-1:0] steps_left;
		coils_t                coil_lines;
		logic [1:0]            enables;
		drive_state_t          expected_drive[$];
		int                    errors;

		function new();
			h_period      = H_PERIOD_RESET;
			v_period      = V_PERIOD_RESET;
			period_in_use = PERIOD_IN_USE_RESET;
			ms_left       = '0;
			mode          = MODE_STOPPED;
			phase         = '0;
			steps_left    = '0;
			coil_lines    = '0;
			enables       = '0;
			errors        = 0;
		endfunction

		function void set_period(logic idx, period_t value);
			if (idx == REG_H_PERIOD)
				h_period = value;
			else
				v_period = value;
		endfunction

		function int pending();
			return expected_drive.size();
		endfunction

		function void take_step();
			steps_left--;
			if (steps_left == 0)
				mode = MODE_STOPPED;
			if (mode < MODE_STOPPED) begin
				// Odd modes turn the phase backwards through the table.
				phase = mode[0] ? phase - 1'b1 : phase + 1'b1;
				coil_lines = HALF_STEP[phase];
			end else begin
				coil_lines = '0;
				enables = '0;
			end
		endfunction

		function void note_word(logic act, logic ax, logic signed [AMOUNT_BITS-1:0] amt);
			logic [AMOUNT_BITS-1:0] raw;
			logic [AMOUNT_BITS-1:0] mag;
			logic [AMOUNT_BITS-1:0] count;
			period_t                per;
			mode_t                  new_mode;
			logic                   was_idle;
			drive_state_t           next;
			raw = amt;
			if (act == ACT_MOVE) begin
				mag = raw[AMOUNT_BITS-1] ? -raw : raw;
				per = ax ? v_period : h_period;
				if (per == 0)
					per = 1;
				was_idle = (steps_left == 0);
				period_in_use = per;
				if (raw == 0)
					new_mode = MODE_STOPPED;
				else if (ax)
					new_mode = raw[AMOUNT_BITS-1] ? MODE_V_NEG : MODE_V_POS;
				else
					new_mode = raw[AMOUNT_BITS-1] ? MODE_H_NEG : MODE_H_POS;
				if (new_mode != mode) begin
					mode = new_mode;
					if (new_mode == MODE_STOPPED)
						enables = 2'b00;
					else
						enables = ax ? 2'b10 : 2'b01;
				end
				count = mag / per;
				// Only the most negative amount can overflow the step counter.
				if ((count >> COUNT_BITS) != 0)
					steps_left = '1;
				else
					steps_left = count[COUNT_BITS-1:0];
				if (was_idle && steps_left != 0)
					ms_left = '0;
			end else if (steps_left != 0) begin
				if (ms_left == 0) begin
					take_step();
					ms_left = period_in_use - 1'b1;
				end else begin
					ms_left--;
				end
			end
			next.coils    = coil_lines;
			next.h_enable = enables[0];
			next.v_enable = enables[1];
			next.running  = (steps_left != 0);
			expected_drive.push_back(next);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_word(drive_state_t got);
			drive_state_t want;
			if (expected_drive.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, actual %h", $time, got);
				return;
			end
			want = expected_drive.pop_front();
			compare_field("coils", want.coils, got.coils);
			compare_field("h_enable", want.h_enable, got.h_enable);
			compare_field("v_enable", want.v_enable, got.v_enable);
			compare_field("running", want.running, got.running);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic    cfg_index;
	period_t cfg_data;

	dahsd_cmd_if cmd_bus ();
	dahsd_res_if res_bus ();

	dual_axis_half_step_driver_top #(
		.COUNT_BITS (COUNT_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.res       (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	drive_scoreboard sb = new();

	int      cycle_count = 0;
	int      stall_count = 0;
	int      burst_left  = 0;
	int      words_sent  = 0;
	period_t cur_h       = H_PERIOD_RESET;
	period_t cur_v       = V_PERIOD_RESET;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver moves through open, random and fixed stall patterns.
	always @(negedge clk) begin
		stall_count <= stall_count + 1;
		case ((stall_count / 700) % 3)
			0: res_bus.ready <= 1'b1;
			1: res_bus.ready <= ($urandom_range(0, 99) < 65);
			default: res_bus.ready <= ((stall_count % 5) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
			sb.check_word({res_bus.coils, res_bus.h_enable, res_bus.v_enable, res_bus.running});
	end

	// Entered just after a falling edge; returns just after a falling edge with
	// valid still high, so the next word can follow without a gap.
	task automatic put_word(input logic act, input logic ax,
			input logic signed [AMOUNT_BITS-1:0] amt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		cmd_bus.valid  <= 1'b1;
		cmd_bus.action <= act;
		cmd_bus.axis   <= ax;
		cmd_bus.amount <= amt;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		sb.note_word(act, ax, amt);
		words_sent++;
		@(negedge clk);
	endtask

	// Tick words carry random axis and amount bits, which the block ignores.
	task automatic send_ticks(input int count);
		repeat (count) put_word(ACT_TICK, 1'($urandom_range(0, 1)), AMOUNT_BITS'($urandom));
	endtask

	task automatic settle();
		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_periods(input period_t h, input period_t v);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_H_PERIOD;
		cfg_data  <= h;
		@(negedge clk);
		cfg_index <= REG_V_PERIOD;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_period(REG_H_PERIOD, h);
		sb.set_period(REG_V_PERIOD, v);
		cur_h = h;
		cur_v = v;
	endtask

	task automatic random_phase(input int words);
		int   first;
		int   pick;
		int   per;
		int   steps;
		int   mag;
		int   ticks;
		logic ax;
		logic neg;
		first = words_sent;
		while (words_sent - first < words) begin
			pick = $urandom_range(0, 99);
			ax   = 1'($urandom_range(0, 1));
			neg  = 1'($urandom_range(0, 1));
			per  = ax ? int'(cur_v) : int'(cur_h);
			if (per == 0)
				per = 1;
			if (pick < 70) begin
				// A move followed by enough ticks to run it out, sometimes cut short.
				steps = (per > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
				mag   = steps * per + $urandom_range(0, per - 1);
				put_word(ACT_MOVE, ax, AMOUNT_BITS'(neg ? -mag : mag));
				ticks = (steps - 1) * per + 1 + $urandom_range(0, 3);
				if ($urandom_range(0, 4) == 0)
					ticks = $urandom_range(0, ticks);
				send_ticks(ticks);
			end else if (pick < 85) begin
				send_ticks($urandom_range(1, 4));
			end else begin
				case ($urandom_range(0, 2))
					0: put_word(ACT_MOVE, ax, '0);
					1: put_word(ACT_MOVE, ax, AMOUNT_BITS'($urandom));
					default: begin
						mag = $urandom_range(0, per - 1);
						put_word(ACT_MOVE, ax, AMOUNT_BITS'(neg ? -mag : mag));
					end
				endcase
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_H_PERIOD;
		cfg_data       = '0;
		cmd_bus.valid  = 1'b0;
		cmd_bus.action = ACT_MOVE;
		cmd_bus.axis   = 1'b0;
		cmd_bus.amount = '0;
		res_bus.ready  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// Reset periods: idle tick, short move, stop, retarget while running.
		send_ticks(1);
		put_word(ACT_MOVE, 1'b0, 14);
		send_ticks(1);
		put_word(ACT_MOVE, 1'b0, 0);
		put_word(ACT_MOVE, 1'b1, 44);
		send_ticks(2);
		put_word(ACT_MOVE, 1'b1, -65535);
		put_word(ACT_MOVE, 1'b1, -65535);
		put_word(ACT_MOVE, 1'b0, 65535);
		put_word(ACT_MOVE, 1'b0, 16);
		send_ticks(2);

		// A zero period acts as one; the most negative amount saturates the count.
		write_periods(8'd0, 8'd1);
		put_word(ACT_MOVE, 1'b0, -17'sd65536);
		send_ticks(2);
		put_word(ACT_MOVE, 1'b0, 65535);
		send_ticks(1);
		put_word(ACT_MOVE, 1'b1, 3);
		send_ticks(3);
		put_word(ACT_MOVE, 1'b1, -2);
		send_ticks(2);

		write_periods(8'd1, 8'd255);
		random_phase(RANDOM_WORDS);
		write_periods(8'd255, 8'd1);
		random_phase(RANDOM_WORDS);
		write_periods(8'd3, 8'd5);
		random_phase(RANDOM_WORDS);
		write_periods(PERIOD_BITS'($urandom_range(1, 12)), PERIOD_BITS'($urandom_range(1, 12)));
		random_phase(RANDOM_WORDS);
		write_periods(PERIOD_BITS'($urandom_range(1, 255)),
			PERIOD_BITS'($urandom_range(1, 255)));
		random_phase(RANDOM_WORDS);

		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
